### hdl/rtbh_pkg.sv
// shared types and constants for the radar threat bucket hold block
package rtbh_pkg;

   localparam int DIST_W = 8;
   localparam int HOLD_W = 16;
   localparam int FUNC_W = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // func codes
   localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD_MS      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLOSE_LIMIT  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MEDIUM_LIMIT = 2'd2;

   localparam logic [HOLD_W-1:0] HOLD_MS_RESET      = 16'd400;
   localparam logic [DIST_W-1:0] CLOSE_LIMIT_RESET  = 8'd40;
   localparam logic [DIST_W-1:0] MEDIUM_LIMIT_RESET = 8'd100;
   localparam logic [DIST_W-1:0] DIST_NONE          = 8'd255;

   // record byte positions after the header
   localparam logic [1:0] PHASE_ID   = 2'd0;
   localparam logic [1:0] PHASE_DIST = 2'd1;
   localparam logic [1:0] PHASE_TAIL = 2'd2;

   typedef struct packed {
      logic [HOLD_W-1:0] hold_ms;
      logic [DIST_W-1:0] close_limit;
      logic [DIST_W-1:0] medium_limit;
   } cfg_type;

   typedef struct packed {
      logic [DIST_W-1:0] closest_distance;
      logic              buzzer_on;
      logic              long_lamp;
      logic              medium_lamp;
      logic              close_lamp;
   } result_type;

endpackage

### hdl/radar_threat_bucket_hold_top.sv
// radar threat bucket hold: input register, core, two-entry result queue
//
// req channel: one word per notification byte, millisecond tick or clear.
//   req_tuser carries the function code, req_tdata the notification byte,
//   req_tlast marks the final byte of a notification.
// rsp channel: exactly one word per accepted req word, in order, giving
//   the three bucket lamps, the buzzer and the closest distance after
//   that word has been applied.
// csr port: csr_we writes csr_wdata into register csr_addr (0 hold_ms,
//   1 close_limit, 2 medium_limit) at the clock edge; index 3 is ignored.
// throughput: one word per cycle while the result queue has room; the parser
//   and hold counters update as each word moves from the input register into the result queue.
// reset: synchronous; clears the parser, counters and queue, nearest
//   distance reads 255 and the registers return to 400, 40 and 100.
// stall: the two-entry result queue keeps taking words while a result
//   waits; req_tready drops only when the queue is full and the input
//   register is occupied, and no word is lost.
module radar_threat_bucket_hold_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] data_byte
   input  logic [rtbh_pkg::FUNC_W-1:0]       req_tuser,  // [1:0] func
   input  logic                              req_tlast,  // last_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] close_lamp, [1] medium_lamp, [2] long_lamp, [3] buzzer_on,
   // [11:4] closest_distance, [15:12] zero
   output logic [rtbh_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [rtbh_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [rtbh_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rtbh_pkg::*;

   cfg_type           cfg_ff;

   logic              s1_valid_ff, s1_valid_in;
   logic [FUNC_W-1:0] s1_func_ff;
   logic [DIST_W-1:0] s1_data_ff;
   logic              s1_last_ff;

   result_type        core_result;
   result_type        queue_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff, count_in;

   logic              req_fire, s1_move, rsp_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ms      <= HOLD_MS_RESET;
         cfg_ff.close_limit  <= CLOSE_LIMIT_RESET;
         cfg_ff.medium_limit <= MEDIUM_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_HOLD_MS:      cfg_ff.hold_ms      <= csr_wdata;
            CSR_CLOSE_LIMIT:  cfg_ff.close_limit  <= csr_wdata[DIST_W-1:0];
            CSR_MEDIUM_LIMIT: cfg_ff.medium_limit <= csr_wdata[DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign s1_move    = s1_valid_ff && (count_ff != 2'd2);
   assign req_tready = !s1_valid_ff || (count_ff != 2'd2);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff <= req_tuser;
         s1_data_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   rtbh_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_move),
      .func       (s1_func_ff),
      .data_byte  (s1_data_ff),
      .last_byte  (s1_last_ff),
      .cfg        (cfg_ff),
      .result     (core_result)
   );

   // result queue
   always_comb begin
      count_in = count_ff;
      if (s1_move && !rsp_fire) begin
         count_in = count_ff + 2'd1;
      end else if (!s1_move && rsp_fire) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (s1_move) wr_ptr_ff <= !wr_ptr_ff;
         if (rsp_fire) rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         queue_ff[wr_ptr_ff] <= core_result;
      end
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, queue_ff[rd_ptr_ff]};

endmodule

### hdl/rtbh_core.sv
// threat record parser, bucket hold counters and nearest distance tracking
module rtbh_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  logic [rtbh_pkg::FUNC_W-1:0]   func,
   input  logic [rtbh_pkg::DIST_W-1:0]   data_byte,
   input  logic                          last_byte,
   input  rtbh_pkg::cfg_type             cfg,
   output rtbh_pkg::result_type          result
);
   import rtbh_pkg::*;

   logic              expect_header_ff, expect_header_in;
   logic [1:0]        record_phase_ff, record_phase_in;
   logic [DIST_W-1:0] pending_distance_ff, pending_distance_in;
   logic              threat_seen_ff, threat_seen_in;
   logic [HOLD_W-1:0] close_hold_ff, close_hold_in;
   logic [HOLD_W-1:0] medium_hold_ff, medium_hold_in;
   logic [HOLD_W-1:0] long_hold_ff, long_hold_in;
   logic [DIST_W-1:0] nearest_ff, nearest_in;

   always_comb begin
      expect_header_in    = expect_header_ff;
      record_phase_in     = record_phase_ff;
      pending_distance_in = pending_distance_ff;
      threat_seen_in      = threat_seen_ff;
      close_hold_in       = close_hold_ff;
      medium_hold_in      = medium_hold_ff;
      long_hold_in        = long_hold_ff;
      nearest_in          = nearest_ff;
      if (item_valid) begin
         case (func)
            FUNC_BYTE: begin
               if (expect_header_ff) begin
                  expect_header_in = 1'b0;
                  record_phase_in  = PHASE_ID;
                  threat_seen_in   = 1'b0;
                  nearest_in       = DIST_NONE;
               end else if (record_phase_ff == PHASE_ID) begin
                  record_phase_in = PHASE_DIST;
               end else if (record_phase_ff == PHASE_DIST) begin
                  pending_distance_in = data_byte;
                  record_phase_in     = PHASE_TAIL;
               end else begin
                  // third byte completes the record
                  if (pending_distance_ff <= cfg.close_limit) begin
                     close_hold_in = cfg.hold_ms;
                  end else if (pending_distance_ff <= cfg.medium_limit) begin
                     medium_hold_in = cfg.hold_ms;
                  end else begin
                     long_hold_in = cfg.hold_ms;
                  end
                  if (pending_distance_ff < nearest_ff) begin
                     nearest_in = pending_distance_ff;
                  end
                  threat_seen_in  = 1'b1;
                  record_phase_in = PHASE_ID;
               end
               if (last_byte) begin
                  if (!threat_seen_in) begin
                     close_hold_in  = '0;
                     medium_hold_in = '0;
                     long_hold_in   = '0;
                  end
                  expect_header_in = 1'b1;
                  record_phase_in  = PHASE_ID;
               end
            end
            FUNC_TICK: begin
               if (close_hold_ff != '0) close_hold_in = close_hold_ff - 1'b1;
               if (medium_hold_ff != '0) medium_hold_in = medium_hold_ff - 1'b1;
               if (long_hold_ff != '0) long_hold_in = long_hold_ff - 1'b1;
            end
            FUNC_CLEAR: begin
               expect_header_in = 1'b1;
               record_phase_in  = PHASE_ID;
               threat_seen_in   = 1'b0;
               close_hold_in    = '0;
               medium_hold_in   = '0;
               long_hold_in     = '0;
               nearest_in       = DIST_NONE;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         record_phase_ff  <= PHASE_ID;
         threat_seen_ff   <= 1'b0;
         close_hold_ff    <= '0;
         medium_hold_ff   <= '0;
         long_hold_ff     <= '0;
         nearest_ff       <= DIST_NONE;
      end else begin
         expect_header_ff <= expect_header_in;
         record_phase_ff  <= record_phase_in;
         threat_seen_ff   <= threat_seen_in;
         close_hold_ff    <= close_hold_in;
         medium_hold_ff   <= medium_hold_in;
         long_hold_ff     <= long_hold_in;
         nearest_ff       <= nearest_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_distance_ff <= pending_distance_in;
   end

   // result reflects the state after this word
   always_comb begin
      result.close_lamp       = (close_hold_in != '0);
      result.medium_lamp      = (medium_hold_in != '0);
      result.long_lamp        = (long_hold_in != '0);
      result.buzzer_on        = (close_hold_in != '0);
      result.closest_distance = nearest_in;
   end

endmodule
